@@ src/urs_pkg.sv @@
package urs_pkg;

   // Field widths
   localparam int POS_W   = 32;
   localparam int HD_W    = 19;
   localparam int VEL_W   = 21;
   localparam int DT_W    = 17;
   localparam int TDATA_W = 128;

   // Internal widths
   localparam int VT_W   = VEL_W + DT_W + 1;   // velocity * step time
   localparam int DIST_W = 22;                 // rounded Q16 distance / angle step
   localparam int Z_W    = 20;                 // CORDIC residual angle
   localparam int XY_W   = 33;                 // CORDIC vector, Q30
   localparam int CS_W   = 32;                 // final cos / sin, Q30
   localparam int PROD_W = DIST_W + CS_W;      // distance * cos / sin
   localparam int NH_W   = 24;                 // unwrapped heading sum
   localparam int SUM_W  = POS_W + 2;          // position plus delta

   // Q16 angle constants
   localparam logic signed [Z_W-1:0]  HALF_PI_Z = Z_W'(102944);
   localparam logic signed [Z_W-1:0]  PI_Z      = Z_W'(205887);
   localparam logic signed [NH_W-1:0] PI_NH     = NH_W'(205887);
   localparam logic signed [NH_W-1:0] TWO_PI_NH = NH_W'(411775);

   // Gain-compensated unit vector, Q30
   localparam logic signed [XY_W-1:0] CORDIC_START = XY_W'(652032874);

   localparam logic signed [SUM_W-1:0] POS_MAX = SUM_W'(64'sd2147483647);
   localparam logic signed [SUM_W-1:0] POS_MIN = -SUM_W'(64'sd2147483648);

   // Pose and command fields carried alongside the CORDIC
   typedef struct packed {
      logic signed [POS_W-1:0]  px;
      logic signed [POS_W-1:0]  py;
      logic signed [HD_W-1:0]   hd;
      logic signed [VEL_W-1:0]  lin;
      logic signed [VEL_W-1:0]  ang;
      logic signed [DIST_W-1:0] travel;
      logic signed [DIST_W-1:0] dth;
      logic signed [NH_W-1:0]   nh;
      logic                     neg;
   } side_type;

   // round(atan(2^-i) * 65536)
   function automatic logic signed [Z_W-1:0] atan_q16(input int idx);
      logic signed [Z_W-1:0] r;
      case (idx)
         0:  r = Z_W'(51472);
         1:  r = Z_W'(30386);
         2:  r = Z_W'(16055);
         3:  r = Z_W'(8150);
         4:  r = Z_W'(4091);
         5:  r = Z_W'(2047);
         6:  r = Z_W'(1024);
         7:  r = Z_W'(512);
         8:  r = Z_W'(256);
         9:  r = Z_W'(128);
         10: r = Z_W'(64);
         11: r = Z_W'(32);
         12: r = Z_W'(16);
         13: r = Z_W'(8);
         14: r = Z_W'(4);
         15: r = Z_W'(2);
         16: r = Z_W'(1);
         default: r = '0;
      endcase
      return r;
   endfunction

   // One wrap correction of the heading sum
   function automatic logic signed [NH_W-1:0] wrap_once(input logic signed [NH_W-1:0] a);
      logic signed [NH_W-1:0] r;
      if (a > PI_NH) begin
         r = a - TWO_PI_NH;
      end else if (a < -PI_NH) begin
         r = a + TWO_PI_NH;
      end else begin
         r = a;
      end
      return r;
   endfunction

endpackage

@@ src/unicycle_rollout_step_top.sv @@
// Channel   Dir  Beat carries (tdata, low bit first)
// req_      in   pose_x, pose_y, heading, cmd_linear, cmd_angular
// rsp_      out  next_x, next_y, next_heading, next_linear, next_angular
// csr_      in   step_time (write only)
//
// One beat per cycle in, one per cycle out. A result beat passes through an input
// stage, one stage per CORDIC iteration, then cos/sin sign fix, the distance
// multiply, and the rounding/saturation output register (ANGLE_ITERATIONS + 4
// register stages). Ready is combinational through every stage, so bubbles are
// squeezed out and the input stalls only when all stages hold a beat.
// Reset clears the stage valids and sets step_time to 6554.
module unicycle_rollout_step_top
   import urs_pkg::*;
#(
   parameter int ANGLE_ITERATIONS = 16   // 8 .. 24
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // pose_x[31:0] pose_y[63:32] heading[82:64] cmd_linear[103:83]
   // cmd_angular[124:104], zero fill above
   input  logic [TDATA_W-1:0]  req_tdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // next_x[31:0] next_y[63:32] next_heading[82:64] next_linear[103:83]
   // next_angular[124:104], zero fill above
   output logic [TDATA_W-1:0]  rsp_tdata,
   input  logic                csr_we,
   input  logic [DT_W-1:0]     csr_wdata
);

   localparam int N     = ANGLE_ITERATIONS;
   localparam int DEPTH = N + 4;
   localparam int S_CS  = N + 1;   // cos/sin sign fix
   localparam int S_MUL = N + 2;   // distance multiply
   localparam int S_OUT = N + 3;   // output register

   localparam logic signed [VT_W-1:0]   RND16 = VT_W'(32768);
   localparam logic signed [PROD_W-1:0] RND30 = PROD_W'(64'sd536870912);

   // ---------------------------------------------------------------
   // Step time register
   // ---------------------------------------------------------------
   logic [DT_W-1:0] step_time_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_time_ff <= DT_W'(6554);
      end else if (csr_we) begin
         step_time_ff <= csr_wdata;
      end
   end

   // ---------------------------------------------------------------
   // Stage valids and ready chain
   // ---------------------------------------------------------------
   logic vld_ff [0:DEPTH-1];
   logic rdy    [0:DEPTH-1];

   always_comb begin
      rdy[DEPTH-1] = !vld_ff[DEPTH-1] || rsp_tready;
      for (int s = DEPTH - 2; s >= 0; s--) begin
         rdy[s] = !vld_ff[s] || rdy[s+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < DEPTH; s++) begin
            vld_ff[s] <= 1'b0;
         end
      end else begin
         if (rdy[0]) begin
            vld_ff[0] <= req_tvalid;
         end
         for (int s = 1; s < DEPTH; s++) begin
            if (rdy[s]) begin
               vld_ff[s] <= vld_ff[s-1];
            end
         end
      end
   end

   assign req_tready = rdy[0];
   assign rsp_tvalid = vld_ff[DEPTH-1];

   // ---------------------------------------------------------------
   // Input stage: scale velocities by the step, fold heading into
   // a quarter turn either side of zero
   // ---------------------------------------------------------------
   logic signed [HD_W-1:0]  req_hd;
   logic signed [VEL_W-1:0] req_lin;
   logic signed [VEL_W-1:0] req_ang;
   logic signed [VT_W-1:0]  vdt;
   logic signed [VT_W-1:0]  wdt;
   logic signed [VT_W-1:0]  vdt_r;
   logic signed [VT_W-1:0]  wdt_r;
   logic signed [Z_W-1:0]   hd_z;
   logic signed [Z_W-1:0]   z0_in;
   side_type                side0_in;

   assign req_hd  = req_tdata[82:64];
   assign req_lin = req_tdata[103:83];
   assign req_ang = req_tdata[124:104];

   always_comb begin
      vdt   = VT_W'(req_lin) * VT_W'($signed({1'b0, step_time_ff}));
      wdt   = VT_W'(req_ang) * VT_W'($signed({1'b0, step_time_ff}));
      vdt_r = vdt + RND16;
      wdt_r = wdt + RND16;
      hd_z  = Z_W'(req_hd);

      side0_in        = '0;
      side0_in.px     = req_tdata[31:0];
      side0_in.py     = req_tdata[63:32];
      side0_in.hd     = req_hd;
      side0_in.lin    = req_lin;
      side0_in.ang    = req_ang;
      side0_in.travel = vdt_r[DIST_W+15:16];
      side0_in.dth    = wdt_r[DIST_W+15:16];

      if (hd_z > HALF_PI_Z) begin
         z0_in        = hd_z - PI_Z;
         side0_in.neg = 1'b1;
      end else if (hd_z < -HALF_PI_Z) begin
         z0_in        = hd_z + PI_Z;
         side0_in.neg = 1'b1;
      end else begin
         z0_in        = hd_z;
         side0_in.neg = 1'b0;
      end
   end

   // ---------------------------------------------------------------
   // CORDIC, rotation mode, one iteration per stage
   // ---------------------------------------------------------------
   logic signed [XY_W-1:0] cx_ff [0:N];
   logic signed [XY_W-1:0] cy_ff [0:N];
   logic signed [Z_W-1:0]  cz_ff [0:N];
   logic signed [XY_W-1:0] cx_in [1:N];
   logic signed [XY_W-1:0] cy_in [1:N];
   logic signed [Z_W-1:0]  cz_in [1:N];
   side_type               side_ff [0:S_MUL];

   always_comb begin
      for (int i = 0; i < N; i++) begin
         if (!cz_ff[i][Z_W-1]) begin
            cx_in[i+1] = cx_ff[i] - (cy_ff[i] >>> i);
            cy_in[i+1] = cy_ff[i] + (cx_ff[i] >>> i);
            cz_in[i+1] = cz_ff[i] - atan_q16(i);
         end else begin
            cx_in[i+1] = cx_ff[i] + (cy_ff[i] >>> i);
            cy_in[i+1] = cy_ff[i] - (cx_ff[i] >>> i);
            cz_in[i+1] = cz_ff[i] + atan_q16(i);
         end
      end
   end

   // ---------------------------------------------------------------
   // Back end: sign fix, heading sum and wrap, multiply, round, saturate
   // ---------------------------------------------------------------
   logic signed [XY_W-1:0]   cos_full;
   logic signed [XY_W-1:0]   sin_full;
   logic signed [CS_W-1:0]   cos_ff;
   logic signed [CS_W-1:0]   sin_ff;
   side_type                 side_cs_in;
   logic signed [PROD_W-1:0] pcx_ff;
   logic signed [PROD_W-1:0] pcy_ff;
   logic signed [PROD_W-1:0] pcx_in;
   logic signed [PROD_W-1:0] pcy_in;
   side_type                 side_mul_in;

   always_comb begin
      cos_full = side_ff[N].neg ? -cx_ff[N] : cx_ff[N];
      sin_full = side_ff[N].neg ? -cy_ff[N] : cy_ff[N];

      side_cs_in    = side_ff[N];
      side_cs_in.nh = NH_W'(side_ff[N].hd) + NH_W'(side_ff[N].dth);

      pcx_in = PROD_W'(side_ff[S_CS].travel) * PROD_W'(cos_ff);
      pcy_in = PROD_W'(side_ff[S_CS].travel) * PROD_W'(sin_ff);

      side_mul_in    = side_ff[S_CS];
      side_mul_in.nh = wrap_once(side_ff[S_CS].nh);
   end

   logic signed [PROD_W-1:0] rx;
   logic signed [PROD_W-1:0] ry;
   logic signed [SUM_W-1:0]  sx;
   logic signed [SUM_W-1:0]  sy;
   logic signed [NH_W-1:0]   nh2;
   logic signed [POS_W-1:0]  nx_in;
   logic signed [POS_W-1:0]  ny_in;
   logic signed [HD_W-1:0]   nhd_in;
   logic signed [POS_W-1:0]  nx_ff;
   logic signed [POS_W-1:0]  ny_ff;
   logic signed [HD_W-1:0]   nhd_ff;
   logic signed [VEL_W-1:0]  lin_ff;
   logic signed [VEL_W-1:0]  ang_ff;

   always_comb begin
      rx = pcx_ff + RND30;
      ry = pcy_ff + RND30;
      sx = SUM_W'(side_ff[S_MUL].px) + SUM_W'($signed(rx[PROD_W-1:30]));
      sy = SUM_W'(side_ff[S_MUL].py) + SUM_W'($signed(ry[PROD_W-1:30]));

      if (sx > POS_MAX) begin
         nx_in = POS_MAX[POS_W-1:0];
      end else if (sx < POS_MIN) begin
         nx_in = POS_MIN[POS_W-1:0];
      end else begin
         nx_in = sx[POS_W-1:0];
      end

      if (sy > POS_MAX) begin
         ny_in = POS_MAX[POS_W-1:0];
      end else if (sy < POS_MIN) begin
         ny_in = POS_MIN[POS_W-1:0];
      end else begin
         ny_in = sy[POS_W-1:0];
      end

      // second wrap, then clamp what is still out of range
      nh2 = wrap_once(side_ff[S_MUL].nh);
      if (nh2 > PI_NH) begin
         nhd_in = PI_NH[HD_W-1:0];
      end else if (nh2 < -PI_NH) begin
         nhd_in = HD_W'(-PI_NH);
      end else begin
         nhd_in = nh2[HD_W-1:0];
      end
   end

   // ---------------------------------------------------------------
   // Payload registers, each loads when its stage advances
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         side_ff[0] <= side0_in;
         cx_ff[0]   <= CORDIC_START;
         cy_ff[0]   <= '0;
         cz_ff[0]   <= z0_in;
      end
      for (int s = 1; s <= N; s++) begin
         if (rdy[s]) begin
            side_ff[s] <= side_ff[s-1];
            cx_ff[s]   <= cx_in[s];
            cy_ff[s]   <= cy_in[s];
            cz_ff[s]   <= cz_in[s];
         end
      end
      if (rdy[S_CS]) begin
         side_ff[S_CS] <= side_cs_in;
         cos_ff        <= cos_full[CS_W-1:0];
         sin_ff        <= sin_full[CS_W-1:0];
      end
      if (rdy[S_MUL]) begin
         side_ff[S_MUL] <= side_mul_in;
         pcx_ff         <= pcx_in;
         pcy_ff         <= pcy_in;
      end
      if (rdy[S_OUT]) begin
         nx_ff  <= nx_in;
         ny_ff  <= ny_in;
         nhd_ff <= nhd_in;
         lin_ff <= side_ff[S_MUL].lin;
         ang_ff <= side_ff[S_MUL].ang;
      end
   end

   assign rsp_tdata = {3'b000, ang_ff, lin_ff, nhd_ff, ny_ff, nx_ff};

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   // input stalls only when every stage holds a beat and the sink stalls
   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("input stalled with room in the pipeline");

   // delivered heading is always wrapped into [-pi, pi]
   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[82:64]) <= 19'sd205887 &&
                      $signed(rsp_tdata[82:64]) >= -19'sd205887))
      else $error("next_heading out of range");

   // nothing comes out right after reset
   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result beat right after reset");

   // a stalled result beat stays offered and unchanged
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("result beat changed while stalled");

endmodule
